// ===== rtl/lhc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lhc_pkg
// Shared types and constants of the handle cache: commands, sequencer
// states, configuration register map and reset values.
// ----------------------------------------------------------------------------
package lhc_pkg;

    typedef enum logic [3:0] {
        CMD_LOOKUP     = 4'd0,
        CMD_DROP_HDL   = 4'd1,
        CMD_DROP_KEY   = 4'd2,
        CMD_DROP_ALL   = 4'd3,
        CMD_TOUCH      = 4'd4,
        CMD_HAS_HDL    = 4'd5,
        CMD_PEEK_KEY   = 4'd6,
        CMD_READ_COUNT = 4'd7,
        CMD_TICK       = 4'd8,
        CMD_CLEANUP    = 4'd9
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ACT,
        ST_VCHK,
        ST_VICT,
        ST_VEND,
        ST_FREE,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        REG_ENABLE  = 2'd0,
        REG_MAX     = 2'd1,
        REG_EXPIRY  = 2'd2,
        REG_POLICY  = 2'd3
    } t_reg;

    localparam int MAX_W    = 21;
    localparam int EXPIRY_W = 16;

    typedef struct packed {
        logic                enable;
        logic [MAX_W-1:0]    max_entries;
        logic [EXPIRY_W-1:0] expiry;
        logic                policy;
    } t_cfg;

    localparam logic [MAX_W-1:0]    MAX_RST    = 21'd102400;
    localparam logic [EXPIRY_W-1:0] EXPIRY_RST = 16'd300;

endpackage
`default_nettype wire

// ===== rtl/lhc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lhc_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module lhc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/lhc_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lhc_cfg
// APB-style configuration registers of the handle cache.
// ----------------------------------------------------------------------------
module lhc_cfg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready,
    output lhc_pkg::t_cfg      o_cfg
);
    import lhc_pkg::*;

    t_cfg r_cfg;
    t_reg w_idx;

    assign w_idx  = t_reg'(paddr[3:2]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable      <= 1'b1;
            r_cfg.max_entries <= MAX_RST;
            r_cfg.expiry      <= EXPIRY_RST;
            r_cfg.policy      <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_ENABLE: r_cfg.enable      <= pwdata[0];
                REG_MAX:    r_cfg.max_entries <= pwdata[MAX_W-1:0];
                REG_EXPIRY: r_cfg.expiry      <= pwdata[EXPIRY_W-1:0];
                REG_POLICY: r_cfg.policy      <= pwdata[0];
                default:    r_cfg             <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_ENABLE: prdata = {31'd0, r_cfg.enable};
            REG_MAX:    prdata = {11'd0, r_cfg.max_entries};
            REG_EXPIRY: prdata = {16'd0, r_cfg.expiry};
            REG_POLICY: prdata = {31'd0, r_cfg.policy};
            default:    prdata = 32'd0;
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/lru_handle_cache_with_expiry.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_handle_cache_with_expiry
// Table of keyed handles with least-recently-used eviction and expiry.
// ----------------------------------------------------------------------------
// Use: present a command with i_in_valid; a transaction is taken when
// o_in_ready is high. One result transaction per command leaves on the
// o_out_* channel, held until i_out_ready takes it. The output register
// frees the sequencer: the next command is taken while a result still waits,
// and the sequencer only stalls if a second result is ready behind it.
// The entry table sits in one RAM with registered read; every search walks it
// one entry per cycle. Drop_all, tick, unused codes and a disabled lookup
// finish without a search; other queries, drops, touch, cleanup and a lookup
// hit take one scan. A lookup miss adds a victim scan per eviction and, if
// the new entry is kept, a search for a free slot.
// Valid bits live in flip-flops and are cleared by reset; the RAM contents
// are not touched, and every entry is read in a scan but only used while
// its valid bit is set. Reset also sets the next handle to 1 and the
// seconds clock to 0. Configuration should be taken over the APB port
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module lru_handle_cache_with_expiry #(
    parameter int ENTRIES  = 64,
    parameter int KEY_BITS = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [3:0]  i_command,
    input  wire logic [63:0] i_key_hash,
    input  wire logic [31:0] i_handle_in,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_handle_out,
    output logic             o_hit,
    output logic [31:0]      o_use_count,
    output logic [6:0]       o_occupancy,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import lhc_pkg::*;

    localparam int IW  = $clog2(ENTRIES);
    localparam int CW  = $clog2(ENTRIES + 2);
    localparam int EW  = KEY_BITS + 96;
    localparam logic [IW:0] LAST = (IW + 1)'(ENTRIES);

    t_cfg w_cfg;

    lhc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Control state
    t_state             r_state, n_state;
    t_cmd               r_cmd, n_cmd;
    logic [IW:0]        r_idx, n_idx;
    logic               r_cmp_vld, n_cmp_vld;
    logic [IW-1:0]      r_cmp_idx, n_cmp_idx;
    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [CW-1:0]      r_live, n_live;
    logic [CW-1:0]      r_count, n_count;
    logic [31:0]        r_next_h, n_next_h;
    logic [31:0]        r_now, n_now;
    logic               r_ovld, n_ovld;
    // Per-command working registers
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [31:0]         r_hin, n_hin;
    logic                r_found, n_found;
    logic [IW-1:0]       r_fidx, n_fidx;
    logic [EW-1:0]       r_frec, n_frec;
    logic                r_hfound, n_hfound;
    logic [IW-1:0]       r_hidx, n_hidx;
    logic [31:0]         r_newh, n_newh;
    logic                r_staged, n_staged;
    logic                r_bhave, n_bhave;
    logic [IW-1:0]       r_bidx, n_bidx;
    logic [31:0]         r_bage, n_bage;
    logic [31:0]         r_bh, n_bh;
    // Result staging and output register
    logic [31:0]         r_rhandle, n_rhandle;
    logic                r_rhit, n_rhit;
    logic [31:0]         r_ruses, n_ruses;
    logic [31:0]         r_ohandle, n_ohandle;
    logic                r_ohit, n_ohit;
    logic [31:0]         r_ouses, n_ouses;
    logic [6:0]          r_oocc, n_oocc;

    // RAM port signals
    logic                ram_we, ram_re;
    logic [IW-1:0]       ram_waddr;
    logic [EW-1:0]       ram_wdata, ram_rdata;

    lhc_ram #(
        .WIDTH (EW),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Fields of the entry being compared
    logic [KEY_BITS-1:0] rd_key;
    logic [31:0]         rd_handle, rd_time, rd_age;
    logic                scan_issue, scan_done, ent_ok;
    logic                key_cmd, prim_eq, aux_eq, better;
    logic [MAX_W:0]      limit;
    logic [31:0]         f_uses;

    assign rd_key    = ram_rdata[EW-1:96];
    assign rd_handle = ram_rdata[95:64];
    assign rd_time   = ram_rdata[63:32];
    assign rd_age    = r_now - rd_time;

    assign scan_issue = (r_idx != LAST);
    assign scan_done  = !scan_issue && !r_cmp_vld;
    assign ent_ok     = r_cmp_vld && r_valid[r_cmp_idx];

    assign key_cmd = (r_cmd == CMD_LOOKUP) || (r_cmd == CMD_DROP_KEY)
                  || (r_cmd == CMD_PEEK_KEY);
    assign prim_eq = key_cmd ? (rd_key == r_key) : (rd_handle == r_hin);
    assign aux_eq  = (rd_handle == r_next_h);

    // Victim order: greatest age first, ties to lowest handle; with policy set, lowest handle first
    assign better = !r_bhave || (w_cfg.policy ? (rd_handle < r_bh)
                  : ((rd_age > r_bage) || ((rd_age == r_bage) && (rd_handle < r_bh))));

    assign limit = ({1'b0, w_cfg.max_entries} < (MAX_W + 1)'(ENTRIES))
                 ? {1'b0, w_cfg.max_entries} : (MAX_W + 1)'(ENTRIES);

    assign f_uses = (r_frec[31:0] == 32'hFFFF_FFFF) ? r_frec[31:0] : r_frec[31:0] + 32'd1;

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_out_valid  = r_ovld;
    assign o_handle_out = r_ohandle;
    assign o_hit        = r_ohit;
    assign o_use_count  = r_ouses;
    assign o_occupancy  = r_oocc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
            r_valid   <= '0;
            r_live    <= '0;
            r_next_h  <= 32'd1;
            r_now     <= 32'd0;
            r_ovld    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_cmp_vld <= n_cmp_vld;
            r_valid   <= n_valid;
            r_live    <= n_live;
            r_next_h  <= n_next_h;
            r_now     <= n_now;
            r_ovld    <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_cmp_idx <= n_cmp_idx;
        r_count   <= n_count;
        r_key     <= n_key;
        r_hin     <= n_hin;
        r_found   <= n_found;
        r_fidx    <= n_fidx;
        r_frec    <= n_frec;
        r_hfound  <= n_hfound;
        r_hidx    <= n_hidx;
        r_newh    <= n_newh;
        r_staged  <= n_staged;
        r_bhave   <= n_bhave;
        r_bidx    <= n_bidx;
        r_bage    <= n_bage;
        r_bh      <= n_bh;
        r_rhandle <= n_rhandle;
        r_rhit    <= n_rhit;
        r_ruses   <= n_ruses;
        r_ohandle <= n_ohandle;
        r_ohit    <= n_ohit;
        r_ouses   <= n_ouses;
        r_oocc    <= n_oocc;
    end

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_idx     = r_idx;
        n_cmp_vld = 1'b0;
        n_cmp_idx = r_idx[IW-1:0];
        n_valid   = r_valid;
        n_live    = r_live;
        n_count   = r_count;
        n_next_h  = r_next_h;
        n_now     = r_now;
        n_key     = r_key;
        n_hin     = r_hin;
        n_found   = r_found;
        n_fidx    = r_fidx;
        n_frec    = r_frec;
        n_hfound  = r_hfound;
        n_hidx    = r_hidx;
        n_newh    = r_newh;
        n_staged  = r_staged;
        n_bhave   = r_bhave;
        n_bidx    = r_bidx;
        n_bage    = r_bage;
        n_bh      = r_bh;
        n_rhandle = r_rhandle;
        n_rhit    = r_rhit;
        n_ruses   = r_ruses;
        n_ovld    = r_ovld;
        n_ohandle = r_ohandle;
        n_ohit    = r_ohit;
        n_ouses   = r_ouses;
        n_oocc    = r_oocc;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = r_fidx;
        ram_wdata = {r_frec[EW-1:64], r_now, f_uses};

        // Drop the result once the receiver takes it
        if (r_ovld && i_out_ready) begin
            n_ovld = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_cmd     = t_cmd'(i_command);
                    n_key     = i_key_hash[KEY_BITS-1:0];
                    n_hin     = i_handle_in;
                    n_idx     = '0;
                    n_found   = 1'b0;
                    n_hfound  = 1'b0;
                    n_rhandle = 32'd0;
                    n_rhit    = 1'b0;
                    n_ruses   = 32'd0;
                    n_state   = ST_SCAN;
                    case (t_cmd'(i_command))
                        CMD_LOOKUP: begin
                            if (!w_cfg.enable) begin
                                n_state = ST_DONE;
                            end
                        end
                        CMD_DROP_ALL: begin
                            n_valid = '0;
                            n_live  = '0;
                            n_state = ST_DONE;
                        end
                        CMD_TICK: begin
                            n_now   = r_now + 32'd1;
                            n_state = ST_DONE;
                        end
                        CMD_DROP_HDL, CMD_DROP_KEY, CMD_TOUCH, CMD_HAS_HDL,
                        CMD_PEEK_KEY, CMD_READ_COUNT, CMD_CLEANUP: begin
                            n_state = ST_SCAN;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                ram_re = scan_issue;
                if (scan_issue) begin
                    n_idx     = r_idx + 1'b1;
                    n_cmp_vld = 1'b1;
                end
                if (ent_ok) begin
                    if (r_cmd == CMD_CLEANUP) begin
                        if (rd_age > {16'd0, w_cfg.expiry}) begin
                            n_valid[r_cmp_idx] = 1'b0;
                            n_live             = r_live - 1'b1;
                        end
                    end else begin
                        if (prim_eq && !r_found) begin
                            n_found = 1'b1;
                            n_fidx  = r_cmp_idx;
                            n_frec  = ram_rdata;
                        end
                        if (aux_eq && !r_hfound) begin
                            n_hfound = 1'b1;
                            n_hidx   = r_cmp_idx;
                        end
                    end
                end
                if (scan_done) begin
                    n_state = ST_ACT;
                end
            end

            ST_ACT: begin
                n_state = ST_DONE;
                n_rhit  = r_found;
                case (r_cmd)
                    CMD_LOOKUP: begin
                        if (r_found) begin
                            ram_we    = 1'b1;
                            n_rhandle = r_frec[95:64];
                        end else begin
                            // Miss: claim the next handle, free any holder of it
                            n_newh    = r_next_h;
                            n_rhandle = r_next_h;
                            n_next_h  = (r_next_h == 32'hFFFF_FFFF) ? 32'd1
                                                                    : r_next_h + 32'd1;
                            n_staged  = 1'b1;
                            if (r_hfound) begin
                                n_valid[r_hidx] = 1'b0;
                                n_count         = r_live;
                                n_live          = r_live - 1'b1;
                            end else begin
                                n_count = r_live + 1'b1;
                            end
                            n_state = ST_VCHK;
                        end
                    end
                    CMD_DROP_HDL, CMD_DROP_KEY: begin
                        if (r_found) begin
                            n_valid[r_fidx] = 1'b0;
                            n_live          = r_live - 1'b1;
                        end
                    end
                    CMD_TOUCH: begin
                        ram_we = r_found;
                    end
                    CMD_HAS_HDL: begin
                        n_rhandle = r_found ? r_hin : 32'd0;
                    end
                    CMD_PEEK_KEY: begin
                        n_rhandle = r_found ? r_frec[95:64] : 32'd0;
                    end
                    CMD_READ_COUNT: begin
                        n_ruses = r_found ? r_frec[31:0] : 32'd0;
                    end
                    default: begin
                        n_rhit = 1'b0;
                    end
                endcase
            end

            ST_VCHK: begin
                n_rhit = 1'b0;
                if ((MAX_W + 1)'(r_count) > limit) begin
                    n_idx   = '0;
                    n_bhave = 1'b0;
                    n_state = ST_VICT;
                end else if (r_staged) begin
                    n_idx   = '0;
                    n_state = ST_FREE;
                end else begin
                    n_state = ST_DONE;
                end
            end

            ST_VICT: begin
                ram_re = scan_issue;
                if (scan_issue) begin
                    n_idx     = r_idx + 1'b1;
                    n_cmp_vld = 1'b1;
                end
                if (ent_ok && better) begin
                    n_bhave = 1'b1;
                    n_bidx  = r_cmp_idx;
                    n_bage  = rd_age;
                    n_bh    = rd_handle;
                end
                if (scan_done) begin
                    n_state = ST_VEND;
                end
            end

            ST_VEND: begin
                // The new entry competes with age zero
                n_count = r_count - 1'b1;
                n_state = ST_VCHK;
                if (r_staged && (!r_bhave || (w_cfg.policy ? (r_newh < r_bh)
                        : ((r_bage == 32'd0) && (r_newh < r_bh))))) begin
                    n_staged = 1'b0;
                end else if (r_bhave) begin
                    n_valid[r_bidx] = 1'b0;
                    n_live          = r_live - 1'b1;
                end else begin
                    n_state = ST_DONE;
                end
            end

            ST_FREE: begin
                if (r_idx == LAST) begin
                    n_state = ST_DONE;
                end else if (!r_valid[r_idx[IW-1:0]]) begin
                    ram_we                 = 1'b1;
                    ram_waddr              = r_idx[IW-1:0];
                    ram_wdata              = {r_key, r_newh, r_now, 32'd1};
                    n_valid[r_idx[IW-1:0]] = 1'b1;
                    n_live                 = r_live + 1'b1;
                    n_state                = ST_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            ST_DONE: begin
                // Hold until the output register is free
                if (!r_ovld || i_out_ready) begin
                    n_ovld    = 1'b1;
                    n_ohandle = r_rhandle;
                    n_ohit    = r_rhit;
                    n_ouses   = r_ruses;
                    n_oocc    = 7'(r_live);
                    n_state   = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire
